// File: design/qom_pkg.sv
package qom_pkg;
    localparam int ORDER_SLOTS = 16;
    localparam int EXCHANGES   = 8;
    localparam int SYMBOLS     = 16;
    localparam int CELLS       = EXCHANGES * SYMBOLS;
    localparam int SLOT_W      = 4;
    localparam int CELL_W      = 7;
    localparam int ORD_W       = 1 + 4 + 32 + 24 + 24 + 64;
    localparam int CELL_DW     = 32 + 64;
    localparam int BOOK_W      = 56;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUOTE = 2'd1;
    localparam logic [1:0] CMD_DEAL  = 2'd2;
    localparam logic [1:0] CMD_BOOK  = 2'd3;

    localparam logic [2:0] K_FILL  = 3'd0;
    localparam logic [2:0] K_REST  = 3'd1;
    localparam logic [2:0] K_TAKEN = 3'd2;
    localparam logic [2:0] K_LOAD  = 3'd3;
    localparam logic [2:0] K_DEAL  = 3'd4;
    localparam logic [2:0] K_BOOK  = 3'd5;

    typedef struct packed {
        logic        sell;
        logic [3:0]  symbol;
        logic [31:0] limit;
        logic [23:0] quantity;
        logic [23:0] filled;
        logic [63:0] cost;
    } t_order;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot_out;
        logic [31:0] amount;
        logic [31:0] price_out;
        logic [23:0] order_filled;
        logic [63:0] total_cost;
        logic        last;
    } t_result;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction
endpackage

// File: design/quote_order_matcher_core.sv
// A load or query beat passes through S_RD and S_FIN before its result beat is registered;
// the next beat is accepted only once that result beat has been taken.
// A quote reads the order slots one at a time in S_RD and S_EVAL, and each fill passes
// through S_MUL, S_WR and S_OUT; result beats wait for m_tready.
// After reset a clearing pass over the 2*CELLS book entries zeroes the book, deal and order memories;
// no beat is accepted during it. Reset is synchronous and active low.
module quote_order_matcher_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command
    input  logic [1:0]   s_tuser,
    // order_slot, exchange_id, symbol_id, side, price, size
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // kind
    output logic [2:0]   m_tuser,
    // slot_out, amount, price_out, order_filled, total_cost
    output logic [159:0] m_tdata,
    output logic         m_tlast
);
    import qom_pkg::*;

    typedef enum logic [7:0] {
        S_CLR   = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_RD    = 8'b00000100,
        S_EVAL  = 8'b00001000,
        S_MUL   = 8'b00010000,
        S_WR    = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_FIN   = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]  r_cmd;
    logic [3:0]  r_slotin, r_sym;
    logic [2:0]  r_exch;
    logic        r_side;
    logic [31:0] r_price;
    logic [23:0] r_remain;
    logic [CELL_W:0] r_cnt;
    logic [SLOT_W:0] r_idx;
    logic        r_taken;
    logic [3:0]  r_lastslot;
    logic [23:0] r_deal;
    logic [63:0] r_prod;
    t_order      r_ord;
    t_result     r_res;
    logic        r_resv, r_fin_done;

    logic cell_ok;
    logic [CELL_W-1:0] cell_idx;
    assign cell_ok = ({1'b0, r_exch} < 4'(EXCHANGES)) && ({1'b0, r_sym} < 5'(SYMBOLS));
    assign cell_idx = {r_exch, r_sym};

    // Memories
    logic            ord_we;
    logic [SLOT_W-1:0] ord_wa, ord_ra;
    t_order          ord_wd, ord_rd;
    logic            cel_we;
    logic [CELL_DW-1:0] cel_wd, cel_rd;
    logic            bk_we;
    logic [CELL_W:0] bk_wa, bk_ra;
    logic [BOOK_W-1:0] bk_wd, bk_rd;
    logic [CELL_W-1:0] cel_wa;

    qom_ram #(.WIDTH(ORD_W), .DEPTH(ORDER_SLOTS)) u_ord (
        .i_clk, .i_we(ord_we), .i_waddr(ord_wa), .i_wdata(ord_wd),
        .i_raddr(ord_ra), .o_rdata(ord_rd));
    qom_ram #(.WIDTH(CELL_DW), .DEPTH(CELLS)) u_deal (
        .i_clk, .i_we(cel_we), .i_waddr(cel_wa), .i_wdata(cel_wd),
        .i_raddr(cell_idx), .o_rdata(cel_rd));
    qom_ram #(.WIDTH(BOOK_W), .DEPTH(2*CELLS)) u_book (
        .i_clk, .i_we(bk_we), .i_waddr(bk_wa), .i_wdata(bk_wd),
        .i_raddr(bk_ra), .o_rdata(bk_rd));

    assign s_tready = (r_state == S_IDLE);
    assign ord_ra   = r_idx[SLOT_W-1:0];
    assign bk_ra    = {r_side, cell_idx};

    // Match evaluation on the slot just read.
    logic match, open;
    logic [24:0] fsum;
    assign match = (r_side == 1'b0) ? (ord_rd.sell && r_price >= ord_rd.limit)
                                    : (!ord_rd.sell && r_price <= ord_rd.limit);
    assign open  = (ord_rd.filled < ord_rd.quantity) && (ord_rd.symbol == r_sym);
    assign fsum  = {1'b0, ord_rd.filled} + {1'b0, r_remain};

    logic [32:0] qsum;
    assign qsum = {1'b0, cel_rd[CELL_DW-1:64]} + {9'd0, r_deal};

    logic [55:0] mul_out;
    assign mul_out = r_price * r_deal;

    always_comb begin
        ord_we = 1'b0; ord_wa = r_idx[SLOT_W-1:0]; ord_wd = r_ord;
        cel_we = 1'b0; cel_wa = cell_idx; cel_wd = '0;
        bk_we = 1'b0; bk_wa = {r_side, cell_idx}; bk_wd = {r_remain, r_price};
        if (r_state == S_CLR) begin
            ord_we = (r_cnt < (CELL_W+1)'(ORDER_SLOTS));
            ord_wa = r_cnt[SLOT_W-1:0];
            ord_wd = '0;
            cel_we = 1'b1; cel_wa = r_cnt[CELL_W-1:0];
            bk_we = 1'b1; bk_wa = r_cnt; bk_wd = '0;
        end else if (r_state == S_WR) begin
            ord_we = 1'b1;
            ord_wd.cost = sat_add64(r_ord.cost, r_prod);
            cel_we = cell_ok;
            cel_wd = {qsum[32] ? 32'hFFFF_FFFF : qsum[31:0],
                      sat_add64(cel_rd[63:0], r_prod)};
        end else if (r_state == S_FIN && !r_fin_done) begin
            ord_we = (r_cmd == CMD_LOAD) && ({1'b0, r_slotin} < 5'(ORDER_SLOTS));
            ord_wa = r_slotin;
            ord_wd = '{sell: r_side, symbol: r_sym, limit: r_price,
                       quantity: r_remain, filled: 24'd0, cost: 64'd0};
            bk_we = (r_cmd == CMD_QUOTE) && !r_taken && cell_ok;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_cnt == (CELL_W+1)'(2*CELLS-1)) n_state = S_IDLE;
            S_IDLE: if (s_tvalid) n_state = S_RD;
            // The deal and book reads of a query are valid once S_RD has passed.
            S_RD:   n_state = (r_cmd == CMD_QUOTE) ? S_EVAL : S_FIN;
            S_EVAL: n_state = (match && open) ? S_MUL
                   : (r_idx == (SLOT_W+1)'(ORDER_SLOTS-1)) ? S_FIN : S_RD;
            S_MUL:  n_state = S_WR;
            S_WR:   n_state = S_OUT;
            S_OUT:  if (!r_resv) n_state = (r_taken ||
                        r_idx == (SLOT_W+1)'(ORDER_SLOTS-1)) ? S_FIN : S_RD;
            S_FIN:  if (r_fin_done && !r_resv) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_cnt <= '0; r_resv <= 1'b0;
            r_fin_done <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_resv && m_tready) r_resv <= 1'b0;
            unique case (r_state)
                S_CLR: r_cnt <= r_cnt + 1'b1;
                S_IDLE: if (s_tvalid) begin
                    r_cmd <= s_tuser; r_slotin <= s_tdata[3:0];
                    r_exch <= s_tdata[6:4]; r_sym <= s_tdata[10:7];
                    r_side <= s_tdata[11]; r_price <= s_tdata[43:12];
                    r_remain <= s_tdata[67:44];
                    r_idx <= '0; r_taken <= 1'b0;
                    r_lastslot <= '0; r_fin_done <= 1'b0;
                end
                S_RD: ;
                S_EVAL: begin
                    r_ord <= ord_rd;
                    if (match && open) begin
                        if (fsum > {1'b0, ord_rd.quantity}) begin
                            r_deal <= ord_rd.quantity - ord_rd.filled;
                        end else begin
                            r_deal <= r_remain;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MUL: begin
                    r_prod <= {8'd0, mul_out};
                    r_ord.filled <= r_ord.filled + r_deal;
                    if (r_deal == r_remain) r_taken <= 1'b1;
                    r_remain <= r_remain - r_deal;
                end
                S_WR: begin
                    r_ord.cost <= ord_wd.cost;
                    r_lastslot <= r_idx[SLOT_W-1:0];
                end
                S_OUT: if (!r_resv) begin
                    r_resv <= 1'b1;
                    r_res <= '{kind: K_FILL, slot_out: r_idx[SLOT_W-1:0],
                               amount: {8'd0, r_deal}, price_out: r_price,
                               order_filled: r_ord.filled, total_cost: r_ord.cost,
                               last: 1'b0};
                    r_idx <= r_idx + 1'b1;
                end
                S_FIN: if (!r_fin_done && !r_resv) begin
                    r_fin_done <= 1'b1;
                    r_resv <= 1'b1;
                    case (r_cmd)
                        CMD_LOAD: r_res <= '{K_LOAD, r_slotin, {8'd0, r_remain}, r_price,
                                             24'd0, 64'd0, 1'b1};
                        CMD_DEAL: r_res <= '{K_DEAL, 4'd0,
                                             cell_ok ? cel_rd[CELL_DW-1:64] : 32'd0, 32'd0,
                                             24'd0, cell_ok ? cel_rd[63:0] : 64'd0, 1'b1};
                        CMD_BOOK: r_res <= '{K_BOOK, 4'd0,
                                             cell_ok ? {8'd0, bk_rd[55:32]} : 32'd0,
                                             cell_ok ? bk_rd[31:0] : 32'd0,
                                             24'd0, 64'd0, 1'b1};
                        default: r_res <= r_taken
                            ? '{K_TAKEN, r_lastslot, 32'd0, r_price, 24'd0, 64'd0, 1'b1}
                            : '{K_REST, 4'd0, {8'd0, r_remain}, r_price, 24'd0, 64'd0,
                                1'b1};
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = r_resv;
    assign m_tlast  = r_res.last;
    assign m_tuser  = r_res.kind;
    assign m_tdata  = {4'd0, r_res.total_cost, r_res.order_filled, r_res.price_out,
                       r_res.amount, r_res.slot_out};

    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !m_tvalid || m_tlast) else $error("accept while fill pending");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result dropped");
    ap_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !s_tready) else $error("accept during clear");
    ap_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> $past(r_state == S_MUL))
        else $error("write without fill");
endmodule

// File: design/qom_ram.sv
module qom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: tb/tb_quote_order_matcher_core.sv
module tb_quote_order_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import qom_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_ITEMS    = 40;
    localparam int RANDOM_ITEMS   = 260;

    typedef struct {
        logic [1:0]  command;
        logic [3:0]  order_slot;
        logic [2:0]  exchange_id;
        logic [3:0]  symbol_id;
        logic        side;
        logic [31:0] price;
        logic [23:0] size;
    } t_request;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // command
    logic [1:0]   s_tuser;
    // order_slot, exchange_id, symbol_id, side, price, size
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // kind
    logic [2:0]   m_tuser;
    // slot_out, amount, price_out, order_filled, total_cost
    logic [159:0] m_tdata;
    logic         m_tlast;

    quote_order_matcher_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the order table, deal totals and level-1 book.
    logic        sh_sell     [ORDER_SLOTS];
    logic [3:0]  sh_symbol   [ORDER_SLOTS];
    logic [31:0] sh_limit    [ORDER_SLOTS];
    logic [23:0] sh_quantity [ORDER_SLOTS];
    logic [23:0] sh_filled   [ORDER_SLOTS];
    logic [63:0] sh_cost     [ORDER_SLOTS];
    logic [31:0] sh_deal_qty  [CELLS];
    logic [63:0] sh_deal_cost [CELLS];
    logic [23:0] sh_bid_size  [CELLS];
    logic [31:0] sh_bid_price [CELLS];
    logic [23:0] sh_ask_size  [CELLS];
    logic [31:0] sh_ask_price [CELLS];

    t_request pending_requests[$];
    t_result  expected_beats[$];

    int  errors = 0;
    int  requests_sent = 0;
    int  beats_seen = 0;
    int  fills_seen = 0;
    int  idle_cycles = 0;
    bit  quiet_phase = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_count = 0;
    bit  hold_done = 0;
    bit  tx_taken = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] add_saturated(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic t_result make_beat(logic [2:0] kind, logic [3:0] slot,
                                          logic [31:0] amount, logic [31:0] price,
                                          logic [23:0] filled, logic [63:0] cost,
                                          logic last);
        t_result r;
        r.kind = kind;
        r.slot_out = slot;
        r.amount = amount;
        r.price_out = price;
        r.order_filled = filled;
        r.total_cost = cost;
        r.last = last;
        return r;
    endfunction

    task automatic queue_beat(input t_result b);
        expected_beats.insert(expected_beats.size(), b);
    endtask

    task automatic predict_match(input t_request rq);
        logic [6:0]  cell_idx;
        logic [23:0] remain;
        logic [23:0] deal;
        logic [3:0]  last_slot;
        logic [32:0] qty_sum;
        logic [63:0] notional;
        bit          taken;
        bit          hit;
        cell_idx = {rq.exchange_id, rq.symbol_id};
        case (rq.command)
            CMD_LOAD: begin
                sh_sell[rq.order_slot] = rq.side;
                sh_symbol[rq.order_slot] = rq.symbol_id;
                sh_limit[rq.order_slot] = rq.price;
                sh_quantity[rq.order_slot] = rq.size;
                sh_filled[rq.order_slot] = '0;
                sh_cost[rq.order_slot] = '0;
                queue_beat(make_beat(K_LOAD, rq.order_slot, 32'(rq.size),
                                     rq.price, '0, '0, 1'b1));
            end
            CMD_DEAL: begin
                queue_beat(make_beat(K_DEAL, '0, sh_deal_qty[cell_idx], '0, '0,
                                     sh_deal_cost[cell_idx], 1'b1));
            end
            CMD_BOOK: begin
                if (rq.side) begin
                    queue_beat(make_beat(K_BOOK, '0, 32'(sh_ask_size[cell_idx]),
                                         sh_ask_price[cell_idx], '0, '0, 1'b1));
                end else begin
                    queue_beat(make_beat(K_BOOK, '0, 32'(sh_bid_size[cell_idx]),
                                         sh_bid_price[cell_idx], '0, '0, 1'b1));
                end
            end
            default: begin
                remain = rq.size;
                taken = 0;
                last_slot = '0;
                for (int i = 0; i < ORDER_SLOTS && !taken; i++) begin
                    if (rq.side == 1'b0)
                        hit = sh_sell[i] && rq.price >= sh_limit[i];
                    else
                        hit = !sh_sell[i] && rq.price <= sh_limit[i];
                    if (!hit || sh_filled[i] >= sh_quantity[i] || sh_symbol[i] != rq.symbol_id)
                        continue;
                    if ({1'b0, sh_filled[i]} + {1'b0, remain} > {1'b0, sh_quantity[i]}) begin
                        deal = sh_quantity[i] - sh_filled[i];
                        remain = remain - deal;
                    end else begin
                        deal = remain;
                        taken = 1;
                    end
                    notional = 64'(rq.price) * 64'(deal);
                    sh_filled[i] = sh_filled[i] + deal;
                    sh_cost[i] = add_saturated(sh_cost[i], notional);
                    qty_sum = {1'b0, sh_deal_qty[cell_idx]} + 33'(deal);
                    sh_deal_qty[cell_idx] = qty_sum[32] ? 32'hFFFF_FFFF : qty_sum[31:0];
                    sh_deal_cost[cell_idx] = add_saturated(sh_deal_cost[cell_idx], notional);
                    queue_beat(make_beat(K_FILL, 4'(i), 32'(deal), rq.price,
                                         sh_filled[i], sh_cost[i], 1'b0));
                    last_slot = 4'(i);
                end
                if (taken) begin
                    queue_beat(make_beat(K_TAKEN, last_slot, '0, rq.price, '0, '0, 1'b1));
                end else begin
                    if (rq.side) begin
                        sh_ask_size[cell_idx] = remain;
                        sh_ask_price[cell_idx] = rq.price;
                    end else begin
                        sh_bid_size[cell_idx] = remain;
                        sh_bid_price[cell_idx] = rq.price;
                    end
                    queue_beat(make_beat(K_REST, '0, 32'(remain), rq.price, '0, '0, 1'b1));
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("ERROR beat %0d: %s got 0x%0h expected 0x%0h", beats_seen, what, got, want);
    endtask

    task automatic queue_request(input logic [1:0] cmd, input logic [3:0] slot,
                                 input logic [2:0] exch, input logic [3:0] sym,
                                 input logic side, input logic [31:0] price,
                                 input logic [23:0] size);
        t_request rq;
        rq.command = cmd;
        rq.order_slot = slot;
        rq.exchange_id = exch;
        rq.symbol_id = sym;
        rq.side = side;
        rq.price = price;
        rq.size = size;
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    function automatic logic [31:0] pick_price();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return 32'd10000 + $urandom_range(0, 20);
    endfunction

    function automatic logic [23:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 24'h0;
            1: return 24'($urandom_range(0, 24'hFFFFFF));
            2: return 24'hFFFFFF;
            default: return 24'($urandom_range(1, 60));
        endcase
    endfunction

    // Sampling at the rising edge: predictor and checker.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                t_request rq;
                rq.command = s_tuser;
                rq.order_slot = s_tdata[3:0];
                rq.exchange_id = s_tdata[6:4];
                rq.symbol_id = s_tdata[10:7];
                rq.side = s_tdata[11];
                rq.price = s_tdata[43:12];
                rq.size = s_tdata[67:44];
                predict_match(rq);
            end
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.slot_out = m_tdata[3:0];
                got.amount = m_tdata[35:4];
                got.price_out = m_tdata[67:36];
                got.order_filled = m_tdata[91:68];
                got.total_cost = m_tdata[155:92];
                got.last = m_tlast;
                beats_seen++;
                if (got.kind == K_FILL)
                    fills_seen++;
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat kind", 64'(got.kind), 64'h0);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch("kind", 64'(got.kind), 64'(want.kind));
                    if (got.slot_out != want.slot_out)
                        report_mismatch("slot_out", 64'(got.slot_out), 64'(want.slot_out));
                    if (got.amount != want.amount)
                        report_mismatch("amount", 64'(got.amount), 64'(want.amount));
                    if (got.price_out != want.price_out)
                        report_mismatch("price_out", 64'(got.price_out), 64'(want.price_out));
                    if (got.order_filled != want.order_filled)
                        report_mismatch("order_filled", 64'(got.order_filled),
                                        64'(want.order_filled));
                    if (got.total_cost != want.total_cost)
                        report_mismatch("total_cost", got.total_cost, want.total_cost);
                    if (got.last != want.last)
                        report_mismatch("tlast", 64'(got.last), 64'(want.last));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_quote_order_matcher_core NOT OK");
            $finish;
        end
    end

    // Remembers whether the beat on the bus was accepted at the last rising edge.
    always @(posedge i_clk) begin
        tx_taken <= s_tvalid && s_tready;
    end

    // Sender: a beat holds until accepted, then the next one may follow a gap.
    always @(negedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tuser <= '0;
            s_tdata <= '0;
        end else if (!s_tvalid || tx_taken) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0 && (quiet_phase ||
                         $urandom_range(0, 5) != 0)) begin
                rq = pending_requests.pop_front();
                s_tuser <= rq.command;
                s_tdata <= {4'd0, rq.size, rq.price, rq.side, rq.symbol_id,
                            rq.exchange_id, rq.order_slot};
                s_tvalid <= 1'b1;
                requests_sent++;
            end else begin
                s_tvalid <= 1'b0;
                if (!quiet_phase && pending_requests.size() > 0)
                    tx_gap <= $urandom_range(0, 13);
            end
        end
    end

    // Receiver with random stalls and one long hold-off so the block backs up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (!hold_done && requests_sent >= 120) begin
            m_tready <= 1'b0;
            if (hold_count >= HOLD_CYCLES)
                hold_done <= 1;
            hold_count <= hold_count + 1;
        end else if (quiet_phase) begin
            m_tready <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int sym;
        int waited;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            sh_sell[i] = 0; sh_symbol[i] = '0; sh_limit[i] = '0;
            sh_quantity[i] = '0; sh_filled[i] = '0; sh_cost[i] = '0;
        end
        for (int c = 0; c < CELLS; c++) begin
            sh_deal_qty[c] = '0; sh_deal_cost[c] = '0;
            sh_bid_size[c] = '0; sh_bid_price[c] = '0;
            sh_ask_size[c] = '0; sh_ask_price[c] = '0;
        end

        // Directed part: extremes, every command, splits, zero-size quotes.
        queue_request(CMD_QUOTE, 4'd0, 3'd0, 4'd0, 1'b0, 32'd5, 24'd7);
        queue_request(CMD_BOOK, 4'd0, 3'd0, 4'd0, 1'b0, 32'd0, 24'd0);
        queue_request(CMD_LOAD, 4'd0, 3'd0, 4'd1, 1'b1, 32'd100, 24'd10);
        queue_request(CMD_LOAD, 4'd15, 3'd7, 4'd1, 1'b1, 32'd90, 24'd5);
        queue_request(CMD_LOAD, 4'd3, 3'd0, 4'd15, 1'b0, 32'hFFFF_FFFF, 24'hFFFFFF);
        queue_request(CMD_LOAD, 4'd4, 3'd0, 4'd15, 1'b0, 32'd0, 24'hFFFFFF);
        queue_request(CMD_QUOTE, 4'd0, 3'd2, 4'd1, 1'b0, 32'd100, 24'd12);
        queue_request(CMD_QUOTE, 4'd0, 3'd2, 4'd1, 1'b0, 32'd100, 24'd9);
        queue_request(CMD_QUOTE, 4'd0, 3'd2, 4'd1, 1'b0, 32'd99, 24'd0);
        queue_request(CMD_QUOTE, 4'd0, 3'd7, 4'd15, 1'b1, 32'hFFFF_FFFF, 24'hFFFFFF);
        queue_request(CMD_QUOTE, 4'd0, 3'd7, 4'd15, 1'b1, 32'hFFFF_FFFF, 24'hFFFFFF);
        queue_request(CMD_QUOTE, 4'd0, 3'd7, 4'd15, 1'b1, 32'd0, 24'd0);
        queue_request(CMD_QUOTE, 4'd0, 3'd7, 4'd15, 1'b1, 32'd0, 24'hFFFFFF);
        queue_request(CMD_DEAL, 4'd0, 3'd7, 4'd15, 1'b0, 32'd0, 24'd0);
        queue_request(CMD_DEAL, 4'd0, 3'd2, 4'd1, 1'b1, 32'hFFFF_FFFF, 24'hFFFFFF);
        queue_request(CMD_BOOK, 4'd0, 3'd2, 4'd1, 1'b0, 32'd0, 24'd0);
        queue_request(CMD_BOOK, 4'd0, 3'd7, 4'd15, 1'b1, 32'd0, 24'd0);
        queue_request(CMD_LOAD, 4'd7, 3'd0, 4'd2, 1'b0, 32'd50, 24'd0);
        queue_request(CMD_QUOTE, 4'd0, 3'd1, 4'd2, 1'b1, 32'd40, 24'd3);
        queue_request(CMD_BOOK, 4'd0, 3'd1, 4'd2, 1'b1, 32'd0, 24'd0);

        // Random part: mostly loads and crossing quotes on a few symbols.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sym = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:
                    queue_request(CMD_LOAD, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                  4'(sym), 1'($urandom_range(0, 1)), pick_price(), pick_size());
                6, 7, 8, 9, 10, 11, 12, 13, 14:
                    queue_request(CMD_QUOTE, 4'($urandom_range(0, 15)),
                                  3'($urandom_range(0, 7)), 4'(sym), 1'($urandom_range(0, 1)),
                                  pick_price(), pick_size());
                15, 16:
                    queue_request(CMD_DEAL, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                  4'(sym), 1'($urandom_range(0, 1)), $urandom(),
                                  24'($urandom()));
                default:
                    queue_request(CMD_BOOK, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                  4'(sym), 1'($urandom_range(0, 1)), $urandom(),
                                  24'($urandom()));
            endcase
        end

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_requests.size() <= QUIET_ITEMS);
        quiet_phase = 1;
        wait (pending_requests.size() == 0);
        @(posedge i_clk);
        while (s_tvalid || expected_beats.size() != 0)
            @(posedge i_clk);
        waited = 0;
        while (waited < 60) begin
            @(posedge i_clk);
            waited++;
        end

        $display("run covered %0d requests and %0d result beats, %0d of them fills,",
                 requests_sent, beats_seen, fills_seen);
        $display("including a %0d-cycle output hold-off and %0d mismatches",
                 HOLD_CYCLES, errors);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("tb_quote_order_matcher_core OK");
        end else begin
            $display("tb_quote_order_matcher_core NOT OK");
        end
        $finish;
    end
endmodule
